FILE: design/swrms_pkg.sv
package swrms_pkg;

  // Sample and window geometry.
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned MAX_HALF_WIDTH = 31;
  localparam int unsigned RING_DEPTH     = 64;
  localparam int unsigned SLOT_BITS      = $clog2(RING_DEPTH);
  localparam int unsigned WIDTH_BITS     = 6;
  localparam int unsigned HALF_BITS      = WIDTH_BITS - 1;

  // Arithmetic widths: squares, the sum of up to 63 squares, quotient and root.
  localparam int unsigned SQ_BITS   = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_BITS  = SQ_BITS + SLOT_BITS;
  localparam int unsigned QUOT_BITS = SQ_BITS;
  localparam int unsigned ROOT_BITS = SAMPLE_BITS;
  localparam int unsigned DREM_BITS = SLOT_BITS;
  localparam int unsigned SREM_BITS = ROOT_BITS + 2;

  // Iteration counts of the divider and the square root.
  localparam int unsigned DIV_STEPS  = QUOT_BITS;
  localparam int unsigned SQRT_STEPS = ROOT_BITS;
  localparam int unsigned STEP_BITS  = $clog2(DIV_STEPS);

  localparam logic [WIDTH_BITS-1:0] SMOOTH_WIDTH_RESET = WIDTH_BITS'(1);

  // Commands from the sequencer to the datapath.
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_CLEAR,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_SQRT_STEP
  } swrms_cmd_e;

  typedef struct packed {
    swrms_cmd_e             cmd;
    logic                   wr_en;
    logic [SLOT_BITS-1:0]   wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic [SLOT_BITS-1:0]   count;
  } swrms_ctrl_t;

  typedef struct packed {
    logic                 mac_busy;
    logic [ROOT_BITS-1:0] root;
  } swrms_stat_t;

  typedef struct packed {
    logic load;
    logic frame_end;
  } swrms_res_t;

endpackage

FILE: design/swrms_in_if.sv
interface swrms_in_if;
  logic                               valid;
  logic                               ready;
  logic [swrms_pkg::SAMPLE_BITS-1:0]  amplitude;
  logic                               last_bin;

  modport source (output valid, output amplitude, output last_bin, input ready);
  modport sink (input valid, input amplitude, input last_bin, output ready);
endinterface

FILE: design/swrms_out_if.sv
interface swrms_out_if;
  logic                             valid;
  logic                             ready;
  logic [swrms_pkg::ROOT_BITS-1:0]  rms_value;
  logic                             frame_end;

  modport source (output valid, output rms_value, output frame_end, input ready);
  modport sink (input valid, input rms_value, input frame_end, output ready);
endinterface

FILE: design/sliding_window_rms_smoother.sv
// Each bin is transferred into the sample ring and then checked for due results.
// Each due result then covers a window of N bins (1 to 63) and is made in order by
// a check, squaring and summing through the ring read port, the divider, the square
// root and the hand-over to the output register; one result per bin.
// The output register holds a finished result while the next bin is taken.
// Reset (asynchronous, active low) empties the frame state and sets smooth_width to 1.
module sliding_window_rms_smoother (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  swrms_in_if.sink                            in_i,
  swrms_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [swrms_pkg::WIDTH_BITS-1:0]    cfg_wdata_i
);

  logic [swrms_pkg::WIDTH_BITS-1:0] smooth_width_q;
  logic                             out_vld_q;
  logic [swrms_pkg::ROOT_BITS-1:0]  out_rms_q;
  logic                             out_end_q;
  logic                             out_free;
  swrms_pkg::swrms_ctrl_t           ctrl;
  swrms_pkg::swrms_stat_t           stat;
  swrms_pkg::swrms_res_t            res;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_width_q <= swrms_pkg::SMOOTH_WIDTH_RESET;
    end else if (cfg_we_i) begin
      smooth_width_q <= cfg_wdata_i;
    end
  end

  swrms_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .smooth_width_i (smooth_width_q),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .amplitude_i    (in_i.amplitude),
    .last_bin_i     (in_i.last_bin),
    .out_free_i     (out_free),
    .stat_i         (stat),
    .ctrl_o         (ctrl),
    .res_o          (res)
  );

  swrms_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  // Output register: free when empty or when its result transfers this cycle.
  assign out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_rms_q <= stat.root;
      out_end_q <= res.frame_end;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.rms_value = out_rms_q;
  assign out_o.frame_end = out_end_q;

endmodule

FILE: design/swrms_dp.sv
module swrms_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swrms_pkg::swrms_ctrl_t ctrl_i,
  output swrms_pkg::swrms_stat_t stat_o
);

  logic [swrms_pkg::SAMPLE_BITS-1:0] ring_q [swrms_pkg::RING_DEPTH];
  logic [swrms_pkg::SAMPLE_BITS-1:0] rd_data_q;
  logic [swrms_pkg::SQ_BITS-1:0]     prod_q;
  logic                              rd_vld_q;
  logic                              mul_vld_q;
  logic [swrms_pkg::SUM_BITS-1:0]    acc_q;
  logic [swrms_pkg::DREM_BITS-1:0]   drem_q;
  logic [swrms_pkg::QUOT_BITS-1:0]   quot_q;
  logic [swrms_pkg::SREM_BITS-1:0]   srem_q;
  logic [swrms_pkg::ROOT_BITS-1:0]   root_q;

  logic [swrms_pkg::SUM_BITS-1:0]    op_a;
  logic [swrms_pkg::SUM_BITS-1:0]    op_b;
  logic                              op_sub;
  logic [swrms_pkg::SUM_BITS:0]      sum;
  logic                              ge;
  logic [swrms_pkg::DREM_BITS:0]     div_trial;
  logic [swrms_pkg::SREM_BITS+1:0]   sqrt_trial;

  // Sample ring with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      ring_q[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= ring_q[ctrl_i.rd_addr];
    end
  end

  // Square of each sample read from the ring, registered before accumulation.
  always_ff @(posedge clk_i) begin
    prod_q <= swrms_pkg::SQ_BITS'(rd_data_q) * swrms_pkg::SQ_BITS'(rd_data_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= ctrl_i.rd_en;
      mul_vld_q <= rd_vld_q;
    end
  end

  // Partial remainders shifted up by one dividend bit or two radicand bits.
  assign div_trial  = {drem_q, quot_q[swrms_pkg::QUOT_BITS-1]};
  assign sqrt_trial = {srem_q, quot_q[swrms_pkg::QUOT_BITS-1 -: 2]};

  // Operand selection for the shared adder and subtractor.
  always_comb begin
    op_a   = acc_q;
    op_b   = swrms_pkg::SUM_BITS'(prod_q);
    op_sub = 1'b0;
    if (!mul_vld_q) begin
      case (ctrl_i.cmd)
        swrms_pkg::CMD_DIV_STEP: begin
          op_a   = swrms_pkg::SUM_BITS'(div_trial);
          op_b   = swrms_pkg::SUM_BITS'(ctrl_i.count);
          op_sub = 1'b1;
        end
        swrms_pkg::CMD_SQRT_STEP: begin
          op_a   = swrms_pkg::SUM_BITS'(sqrt_trial);
          op_b   = swrms_pkg::SUM_BITS'({root_q, 2'b01});
          op_sub = 1'b1;
        end
        default: begin
          op_a   = acc_q;
          op_b   = swrms_pkg::SUM_BITS'(prod_q);
          op_sub = 1'b0;
        end
      endcase
    end
  end

  // The shared unit: one wide add or subtract; the carry tells a >= b.
  assign sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)}
             + (swrms_pkg::SUM_BITS + 1)'(op_sub);
  assign ge  = sum[swrms_pkg::SUM_BITS];

  // Accumulator, restoring divider and digit-by-digit square root.
  always_ff @(posedge clk_i) begin
    if (mul_vld_q) begin
      acc_q <= sum[swrms_pkg::SUM_BITS-1:0];
    end else begin
      case (ctrl_i.cmd)
        swrms_pkg::CMD_CLEAR: begin
          acc_q <= '0;
        end
        swrms_pkg::CMD_DIV_INIT: begin
          drem_q <= acc_q[swrms_pkg::SUM_BITS-1 -: swrms_pkg::DREM_BITS];
          quot_q <= acc_q[swrms_pkg::QUOT_BITS-1:0];
          srem_q <= '0;
          root_q <= '0;
        end
        swrms_pkg::CMD_DIV_STEP: begin
          drem_q <= ge ? sum[swrms_pkg::DREM_BITS-1:0]
                       : div_trial[swrms_pkg::DREM_BITS-1:0];
          quot_q <= {quot_q[swrms_pkg::QUOT_BITS-2:0], ge};
        end
        swrms_pkg::CMD_SQRT_STEP: begin
          srem_q <= ge ? sum[swrms_pkg::SREM_BITS-1:0]
                       : sqrt_trial[swrms_pkg::SREM_BITS-1:0];
          quot_q <= {quot_q[swrms_pkg::QUOT_BITS-3:0], 2'b00};
          root_q <= {root_q[swrms_pkg::ROOT_BITS-2:0], ge};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign stat_o.mac_busy = rd_vld_q | mul_vld_q;
  assign stat_o.root     = root_q;

endmodule

FILE: design/swrms_seq.sv
module swrms_seq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [swrms_pkg::WIDTH_BITS-1:0]      smooth_width_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [swrms_pkg::SAMPLE_BITS-1:0]     amplitude_i,
  input  logic                                  last_bin_i,
  input  logic                                  out_free_i,
  input  swrms_pkg::swrms_stat_t                stat_i,
  output swrms_pkg::swrms_ctrl_t                ctrl_o,
  output swrms_pkg::swrms_res_t                 res_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_SQRT  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  localparam logic [swrms_pkg::SLOT_BITS-1:0] ONE = swrms_pkg::SLOT_BITS'(1);
  localparam logic [swrms_pkg::HALF_BITS-1:0] HALF_CAP =
    swrms_pkg::HALF_BITS'(swrms_pkg::MAX_HALF_WIDTH);

  state_e                             state_q, state_d;
  logic [swrms_pkg::SLOT_BITS-1:0]    write_slot_q, write_slot_d;
  logic [swrms_pkg::SLOT_BITS-1:0]    bins_seen_q, bins_seen_d;
  logic [swrms_pkg::SLOT_BITS-1:0]    left_cnt_q, left_cnt_d;
  logic                               last_q, last_d;
  logic [swrms_pkg::HALF_BITS-1:0]    half_q, half_d;
  logic [swrms_pkg::SLOT_BITS-1:0]    k_q, k_d;
  logic [swrms_pkg::SLOT_BITS-1:0]    issue_cnt_q, issue_cnt_d;
  logic [swrms_pkg::SLOT_BITS-1:0]    count_q, count_d;
  logic [swrms_pkg::STEP_BITS-1:0]    step_cnt_q, step_cnt_d;

  logic                               accept;
  logic [swrms_pkg::HALF_BITS-1:0]    half_req;
  logic [swrms_pkg::SLOT_BITS-1:0]    half_ext;
  logic [swrms_pkg::SLOT_BITS-1:0]    lag;
  logic [swrms_pkg::SLOT_BITS-1:0]    right;
  logic [swrms_pkg::SLOT_BITS-1:0]    before_cnt;
  logic [swrms_pkg::SLOT_BITS-1:0]    left;
  logic                               pending;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Half-width of the window, capped at the largest supported value.
  assign half_req = (smooth_width_i[swrms_pkg::WIDTH_BITS-1:1] > HALF_CAP)
                  ? HALF_CAP : smooth_width_i[swrms_pkg::WIDTH_BITS-1:1];

  // Window bounds of the oldest pending bin, cut off at the frame edges.
  assign half_ext   = {1'b0, half_q};
  assign lag        = left_cnt_q - ONE;
  assign right      = (lag < half_ext) ? lag : half_ext;
  assign before_cnt = bins_seen_q - ONE - lag;
  assign left       = (before_cnt < half_ext) ? before_cnt : half_ext;
  assign pending    = last_q ? (left_cnt_q != '0) : (left_cnt_q > half_ext);

  // Sequencer: bookkeeping per bin, then accumulate, divide and root per result.
  always_comb begin
    state_d      = state_q;
    write_slot_d = write_slot_q;
    bins_seen_d  = bins_seen_q;
    left_cnt_d   = left_cnt_q;
    last_d       = last_q;
    half_d       = half_q;
    k_d          = k_q;
    issue_cnt_d  = issue_cnt_q;
    count_d      = count_q;
    step_cnt_d   = step_cnt_q;

    ctrl_o.cmd     = swrms_pkg::CMD_IDLE;
    ctrl_o.wr_en   = 1'b0;
    ctrl_o.wr_addr = write_slot_q;
    ctrl_o.wr_data = amplitude_i;
    ctrl_o.rd_en   = 1'b0;
    ctrl_o.rd_addr = write_slot_q - ONE - k_q;
    ctrl_o.count   = count_q;

    res_o.load      = 1'b0;
    res_o.frame_end = last_q && (left_cnt_q == ONE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl_o.wr_en = 1'b1;
          write_slot_d = write_slot_q + ONE;
          if (bins_seen_q != '1) begin
            bins_seen_d = bins_seen_q + ONE;
          end
          left_cnt_d = left_cnt_q + ONE;
          last_d     = last_bin_i;
          half_d     = half_req;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pending) begin
          ctrl_o.cmd  = swrms_pkg::CMD_CLEAR;
          k_d         = lag - right;
          count_d     = left + right + ONE;
          issue_cnt_d = left + right + ONE;
          state_d     = ST_MAC;
        end else begin
          if (last_q) begin
            bins_seen_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        if (issue_cnt_q != '0) begin
          ctrl_o.rd_en = 1'b1;
          k_d          = k_q + ONE;
          issue_cnt_d  = issue_cnt_q - ONE;
        end else if (!stat_i.mac_busy) begin
          ctrl_o.cmd = swrms_pkg::CMD_DIV_INIT;
          step_cnt_d = swrms_pkg::STEP_BITS'(swrms_pkg::DIV_STEPS - 1);
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl_o.cmd = swrms_pkg::CMD_DIV_STEP;
        step_cnt_d = step_cnt_q - swrms_pkg::STEP_BITS'(1);
        if (step_cnt_q == '0) begin
          step_cnt_d = swrms_pkg::STEP_BITS'(swrms_pkg::SQRT_STEPS - 1);
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        ctrl_o.cmd = swrms_pkg::CMD_SQRT_STEP;
        step_cnt_d = step_cnt_q - swrms_pkg::STEP_BITS'(1);
        if (step_cnt_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          left_cnt_d = left_cnt_q - ONE;
          state_d    = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      write_slot_q <= '0;
      bins_seen_q  <= '0;
      left_cnt_q   <= '0;
      last_q       <= 1'b0;
      half_q       <= '0;
      k_q          <= '0;
      issue_cnt_q  <= '0;
      count_q      <= '0;
      step_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      write_slot_q <= write_slot_d;
      bins_seen_q  <= bins_seen_d;
      left_cnt_q   <= left_cnt_d;
      last_q       <= last_d;
      half_q       <= half_d;
      k_q          <= k_d;
      issue_cnt_q  <= issue_cnt_d;
      count_q      <= count_d;
      step_cnt_q   <= step_cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // Between bins no more results are pending than the half-width allows.
  a_idle_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (left_cnt_q <= half_ext))
    else $error("too many results pending while idle");

  // Every accepted bin is followed by a check for due results.
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CHECK))
    else $error("accepted bin not followed by a check");

  // A window always holds at least its own bin.
  a_mac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (count_q != '0))
    else $error("empty window in accumulation");

  // The square root only starts after the full division.
  a_sqrt_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SQRT) |-> $past(state_q == ST_DIV))
    else $error("square root entered without division");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TARGET_BINS = 310;
  localparam int unsigned IDLE_WAIT   = 200;
  localparam int unsigned RUN_LIMIT   = 20_000_000;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [swrms_pkg::WIDTH_BITS-1:0] cfg_wdata_i;

  swrms_in_if  in_if ();
  swrms_out_if out_if ();

  sliding_window_rms_smoother u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  typedef struct {
    logic [swrms_pkg::ROOT_BITS-1:0] rms_value;
    logic                            frame_end;
  } rms_result_t;

  // Tracks the frame as the block sees it and queues the smoothed values it must give.
  class rms_window_tracker;
    logic [swrms_pkg::SAMPLE_BITS-1:0] ring [swrms_pkg::RING_DEPTH];
    int unsigned                       smooth_width;
    int unsigned                       bins_seen;
    int unsigned                       write_slot;
    int unsigned                       left_count;
    rms_result_t                       pending_rms_q [$];
    int unsigned                       mismatches;

    function new();
      smooth_width = swrms_pkg::SMOOTH_WIDTH_RESET;
      bins_seen    = 0;
      write_slot   = 0;
      left_count   = 0;
      mismatches   = 0;
    endfunction

    function void set_width(input logic [swrms_pkg::WIDTH_BITS-1:0] w);
      smooth_width = w;
    endfunction

    function int unsigned pending();
      return pending_rms_q.size();
    endfunction

    // Floor of the square root, found one bit at a time from the top.
    function logic [swrms_pkg::ROOT_BITS-1:0] floor_sqrt(input logic [63:0] v);
      logic [swrms_pkg::ROOT_BITS-1:0] root;
      logic [63:0]                     trial;
      int                              b;
      root = '0;
      for (b = swrms_pkg::ROOT_BITS - 1; b >= 0; b--) begin
        trial = 64'(root) | (64'd1 << b);
        if (trial * trial <= v) begin
          root = trial[swrms_pkg::ROOT_BITS-1:0];
        end
      end
      return root;
    endfunction

    // RMS over the window of the bin that lies lag positions behind the newest one.
    function logic [swrms_pkg::ROOT_BITS-1:0] window_rms(input int unsigned lag,
                                                         input int unsigned half);
      int unsigned                       right;
      int unsigned                       older;
      int unsigned                       left;
      int unsigned                       count;
      int unsigned                       k;
      logic [swrms_pkg::SUM_BITS-1:0]    sum;
      logic [swrms_pkg::SAMPLE_BITS-1:0] s;
      right = (lag < half) ? lag : half;
      older = bins_seen - 1 - lag;
      left  = (older < half) ? older : half;
      count = left + right + 1;
      sum   = '0;
      for (k = lag - right; k <= lag + left; k++) begin
        s   = ring[(write_slot + swrms_pkg::RING_DEPTH - 1 - k) % swrms_pkg::RING_DEPTH];
        sum = sum + swrms_pkg::SUM_BITS'(s) * swrms_pkg::SUM_BITS'(s);
      end
      return floor_sqrt(64'(sum) / 64'(count));
    endfunction

    // Called on every input transfer; queues the results that this bin makes due.
    function void take_bin(input logic [swrms_pkg::SAMPLE_BITS-1:0] amp, input logic last);
      int unsigned half;
      rms_result_t r;
      half = smooth_width / 2;
      if (half > swrms_pkg::MAX_HALF_WIDTH) begin
        half = swrms_pkg::MAX_HALF_WIDTH;
      end
      ring[write_slot] = amp;
      write_slot = (write_slot + 1) % swrms_pkg::RING_DEPTH;
      if (bins_seen < 63) begin
        bins_seen++;
      end
      left_count++;
      if (last) begin
        // The last bin flushes everything still pending, oldest first.
        while (left_count > 0) begin
          r.rms_value = window_rms(left_count - 1, half);
          r.frame_end = (left_count == 1);
          pending_rms_q.push_back(r);
          left_count--;
        end
        bins_seen = 0;
      end else begin
        while (left_count > half) begin
          r.rms_value = window_rms(left_count - 1, half);
          r.frame_end = 1'b0;
          pending_rms_q.push_back(r);
          left_count--;
        end
      end
    endfunction

    // Called on every output transfer; compares with the oldest queued value.
    function void match_result(input logic [swrms_pkg::ROOT_BITS-1:0] rms, input logic fe);
      rms_result_t exp_r;
      if (pending_rms_q.size() == 0) begin
        $error("unexpected result: rms_value %0d frame_end %0d", rms, fe);
        mismatches++;
        return;
      end
      exp_r = pending_rms_q.pop_front();
      if (rms !== exp_r.rms_value) begin
        $error("rms_value mismatch: expected %0d, actual %0d", exp_r.rms_value, rms);
        mismatches++;
      end
      if (fe !== exp_r.frame_end) begin
        $error("frame_end mismatch: expected %0d, actual %0d", exp_r.frame_end, fe);
        mismatches++;
      end
    endfunction
  endclass

  rms_window_tracker tracker = new();
  int unsigned       bins_sent = 0;
  bit                no_stall = 1'b0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Gap lengths: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_stall) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [swrms_pkg::SAMPLE_BITS-1:0] pick_amp();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return swrms_pkg::SAMPLE_BITS'($urandom);
  endfunction

  function automatic int unsigned pick_frame_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 12);
    end else if (r < 95) begin
      return $urandom_range(13, 40);
    end
    return $urandom_range(60, 80);
  endfunction

  function automatic logic [swrms_pkg::WIDTH_BITS-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 7);
    case (r)
      0: begin
        return swrms_pkg::WIDTH_BITS'(0);
      end
      1: begin
        return swrms_pkg::WIDTH_BITS'(1);
      end
      2: begin
        return swrms_pkg::WIDTH_BITS'(62);
      end
      3: begin
        return swrms_pkg::WIDTH_BITS'(63);
      end
      default: begin
        return swrms_pkg::WIDTH_BITS'($urandom_range(0, 63));
      end
    endcase
  endfunction

  // One input transfer, after a random gap. Returns at the falling edge after it.
  task automatic send_bin(input logic [swrms_pkg::SAMPLE_BITS-1:0] amp, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.amplitude <= amp;
    in_if.last_bin  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.take_bin(amp, last);
    bins_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every queued result has come out and the block is quiet.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (IDLE_WAIT) @(negedge clk_i);
  endtask

  task automatic write_width(input logic [swrms_pkg::WIDTH_BITS-1:0] w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_width(w);
  endtask

  // Output transfers are checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.match_result(out_if.rms_value, out_if.frame_end);
    end
  end

  // Receiver side: bursts of ready with random stalls between them.
  initial begin
    int unsigned g;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      g = pick_gap();
      if (g != 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
  end

  // Main stimulus.
  initial begin
    int unsigned n_frames;
    int unsigned len;
    int unsigned i;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.amplitude = '0;
    in_if.last_bin  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset width passes every bin straight through.
    send_bin(16'h0000, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'hAAAA, 1'b0);
    send_bin(16'h5555, 1'b1);

    // Width zero also passes through.
    wait_idle();
    write_width(swrms_pkg::WIDTH_BITS'(0));
    send_bin(16'h0001, 1'b0);
    send_bin(16'h8000, 1'b0);
    send_bin(16'hFFFF, 1'b1);

    // Widest window on a frame shorter than it, then a one-bin frame.
    wait_idle();
    write_width(swrms_pkg::WIDTH_BITS'(63));
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h1234, 1'b0);
    send_bin(16'hFFFF, 1'b1);
    send_bin(16'h7FFF, 1'b1);

    // Window narrows inside a frame; the sender waits for all results first.
    wait_idle();
    write_width(swrms_pkg::WIDTH_BITS'(6));
    send_bin(16'h0100, 1'b0);
    send_bin(16'h0200, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h0300, 1'b0);
    wait_idle();
    write_width(swrms_pkg::WIDTH_BITS'(2));
    send_bin(16'h0400, 1'b0);
    send_bin(16'hF0F0, 1'b0);
    send_bin(16'h0F0F, 1'b1);

    // Random phases: a width, then a few frames of random length and content.
    while (bins_sent < TARGET_BINS) begin
      wait_idle();
      write_width(pick_width());
      no_stall = ($urandom_range(0, 4) == 0);
      n_frames = $urandom_range(1, 3);
      repeat (n_frames) begin
        // The frame is cut short so that the total stays at the target.
        len = pick_frame_len();
        if (len > TARGET_BINS - bins_sent) begin
          len = TARGET_BINS - bins_sent;
        end
        for (i = 0; i < len; i++) begin
          if (i != 0 && $urandom_range(0, 19) == 0) begin
            wait_idle();
            write_width(swrms_pkg::WIDTH_BITS'($urandom_range(0, 63)));
          end
          send_bin(pick_amp(), i == len - 1);
        end
      end
    end

    no_stall = 1'b0;
    wait_idle();
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
